[src/pf_pkg.sv]
// Shared types, constants and cell arithmetic for the Playfair encryptor.
// Used by pf_ctrl, pf_datapath and playfair_encrypt; depends on nothing.
`timescale 1ns / 1ps

package pf_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] row_t;
  typedef logic [1:0] kind_t;

  localparam letter_t CODE_I    = 5'd8;
  localparam letter_t CODE_J    = 5'd9;
  localparam letter_t CODE_X    = 5'd23;
  localparam letter_t LAST_CODE = letter_t'(LETTERS - 1);
  localparam cell_t   CELL_LIM  = cell_t'(CELLS);

  localparam kind_t KIND_KEY  = 2'd0;
  localparam kind_t KIND_TEXT = 2'd1;
  localparam kind_t KIND_END  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic key_place;   // append an accepted key letter
    logic load_cur;    // latch an accepted plaintext letter
    logic fill_start;  // restart the alphabet sweep
    logic fill_step;   // place one alphabet letter
    logic open_pair;   // keep current letter as first of a pair
    logic close_pair;  // form pair from pending and current letter
    logic end_pair;    // form pair from pending letter and x
    logic pos_sel_b;   // position read: 0 first letter, 1 second letter
    logic cap_pa;      // capture position of first letter
    logic cap_f;       // compute and capture cipher cells
    logic sq_sel_b;    // square read: 0 first cell, 1 second cell
    logic cap_first;   // capture first cipher letter
    logic emit;        // load result register
  } pf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic letter_ok;   // folded input letter is in range
    logic complete;    // square is complete
    logic pending;     // a pair is open
    logic fill_last;   // sweep is on its last letter
    logic out_free;    // result register can take a new result
  } pf_stat_t;

  // Row of a cell, by comparison against row boundaries
  function automatic row_t pf_row(cell_t p);
    row_t r;
    r = '0;
    for (int k = 1; k < SIDE; k++) begin
      if (p >= cell_t'(k * SIDE)) r = row_t'(k);
    end
    return r;
  endfunction

  // Cell index from row and column: row * 5 + col as shifts and adds
  function automatic cell_t pf_cell(row_t r, row_t c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  // Column of a cell
  function automatic row_t pf_col(cell_t p);
    cell_t d;
    d = p - pf_cell(pf_row(p), 3'd0);
    return d[2:0];
  endfunction

  // Cyclic successor of a row or column
  function automatic row_t pf_next(row_t x);
    return (x == row_t'(SIDE - 1)) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

[src/pf_ctrl.sv]
// Controller state machine for the Playfair encryptor.
// Sequences key appends, alphabet sweep, pair forming and square lookups; uses pf_pkg.
`timescale 1ns / 1ps

module pf_ctrl import pf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  kind_t    kind_i,
  input  pf_stat_t stat_i,
  output logic     in_stall_o,
  output pf_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_PAIR, S_RA, S_RB, S_CALC, S_SA, S_SB, S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_KEY: begin
              cmd_o.key_place = stat_i.letter_ok;
            end
            KIND_TEXT: begin
              if (stat_i.letter_ok) begin
                cmd_o.load_cur = 1'b1;
                if (stat_i.complete) begin
                  state_d = S_PAIR;
                end else begin
                  cmd_o.fill_start = 1'b1;
                  state_d = S_FILL;
                end
              end
            end
            KIND_END: begin
              if (stat_i.pending) begin
                cmd_o.end_pair = 1'b1;
                state_d = S_RA;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) state_d = S_PAIR;
      end
      S_PAIR: begin
        if (stat_i.pending) begin
          cmd_o.close_pair = 1'b1;
          state_d = S_RA;
        end else begin
          cmd_o.open_pair = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RA: begin
        state_d = S_RB;
      end
      S_RB: begin
        cmd_o.pos_sel_b = 1'b1;
        cmd_o.cap_pa    = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.cap_f = 1'b1;
        state_d = S_SA;
      end
      S_SA: begin
        state_d = S_SB;
      end
      S_SB: begin
        cmd_o.sq_sel_b  = 1'b1;
        cmd_o.cap_first = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register is free
        cmd_o.sq_sel_b = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/pf_datapath.sv]
// Datapath of the Playfair encryptor: square and position memories, letter flags,
// pair registers, cipher cell arithmetic and result register; uses pf_pkg.
`timescale 1ns / 1ps

module pf_datapath import pf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  letter_t  letter_i,
  input  logic     out_stall_i,
  input  pf_cmd_t  cmd_i,
  output pf_stat_t stat_o,
  output logic     out_valid_o,
  output letter_t  cipher_first_o,
  output letter_t  cipher_second_o
);

  // Memories: letter per cell, cell per letter
  letter_t sq_mem  [CELLS];
  cell_t   pos_mem [LETTERS];

  logic [LETTERS-1:0] present_q, present_d;
  cell_t   fill_q, fill_d;
  logic    complete_q, complete_d;
  logic    pending_q, pending_d;
  letter_t pend_q, cur_q, a_q, b_q, cnt_q;
  cell_t   pa_q, fa_q, fb_q, pos_rd_q;
  letter_t sq_rd_q, first_q;
  logic    out_valid_q;
  letter_t out_first_q, out_second_q;

  letter_t folded;
  logic [LETTERS-1:0] base_present;
  cell_t   base_fill;
  letter_t place_code;
  logic    place_try, place_en;
  letter_t pos_raddr;
  cell_t   sq_raddr;

  assign folded = (letter_i == CODE_J) ? CODE_I : letter_i;

  // A key letter after plaintext starts from an empty square
  always_comb begin
    base_present = present_q;
    base_fill    = fill_q;
    if (cmd_i.key_place && complete_q) begin
      base_present = '0;
      base_fill    = '0;
    end
  end

  assign place_code = cmd_i.key_place ? folded : cnt_q;
  assign place_try  = cmd_i.key_place || (cmd_i.fill_step && (cnt_q != CODE_J));
  assign place_en   = place_try && !base_present[place_code] && (base_fill < CELL_LIM);

  // Next values of square bookkeeping and pair state
  always_comb begin
    present_d  = base_present;
    fill_d     = base_fill;
    complete_d = complete_q;
    pending_d  = pending_q;
    if (place_en) begin
      present_d[place_code] = 1'b1;
      fill_d = base_fill + 5'd1;
    end
    if (cmd_i.key_place && complete_q) begin
      complete_d = 1'b0;
      pending_d  = 1'b0;
    end
    if (cmd_i.fill_step && (cnt_q == LAST_CODE)) complete_d = 1'b1;
    if (cmd_i.open_pair) pending_d = 1'b1;
    if (cmd_i.close_pair || cmd_i.end_pair) pending_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      fill_q      <= '0;
      complete_q  <= 1'b0;
      pending_q   <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      present_q  <= present_d;
      fill_q     <= fill_d;
      complete_q <= complete_d;
      pending_q  <= pending_d;
      if (cmd_i.open_pair) pend_q <= cur_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[base_fill]   <= place_code;
      pos_mem[place_code] <= base_fill;
    end
  end

  // Registered memory reads
  assign pos_raddr = cmd_i.pos_sel_b ? b_q : a_q;
  assign sq_raddr  = cmd_i.sq_sel_b ? fb_q : fa_q;

  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[pos_raddr];
    sq_rd_q  <= sq_mem[sq_raddr];
  end

  // Cipher cells by the row, column and rectangle rules
  row_t ra, ca, rb, cb;
  cell_t fa_d, fb_d;

  always_comb begin
    ra = pf_row(pa_q);
    ca = pf_col(pa_q);
    rb = pf_row(pos_rd_q);
    cb = pf_col(pos_rd_q);
    if (ra == rb) begin
      fa_d = pf_cell(ra, pf_next(ca));
      fb_d = pf_cell(rb, pf_next(cb));
    end else if (ca == cb) begin
      fa_d = pf_cell(pf_next(ra), ca);
      fb_d = pf_cell(pf_next(rb), cb);
    end else begin
      fa_d = pf_cell(ra, cb);
      fb_d = pf_cell(rb, ca);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) cur_q <= folded;
    if (cmd_i.fill_start) begin
      cnt_q <= '0;
    end else if (cmd_i.fill_step) begin
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.close_pair) begin
      a_q <= pend_q;
      b_q <= (cur_q == pend_q) ? CODE_X : cur_q;
    end else if (cmd_i.end_pair) begin
      a_q <= pend_q;
      b_q <= CODE_X;
    end
    if (cmd_i.cap_pa) pa_q <= pos_rd_q;
    if (cmd_i.cap_f) begin
      fa_q <= fa_d;
      fb_q <= fb_d;
    end
    if (cmd_i.cap_first) first_q <= sq_rd_q;
    if (cmd_i.emit) begin
      out_first_q  <= first_q;
      out_second_q <= sq_rd_q;
    end
  end

  assign stat_o.letter_ok = (folded < letter_t'(LETTERS));
  assign stat_o.complete  = complete_q;
  assign stat_o.pending   = pending_q;
  assign stat_o.fill_last = (cnt_q == LAST_CODE);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = out_first_q;
  assign cipher_second_o = out_second_q;

endmodule

[src/playfair_encrypt.sv]
// Playfair encryptor top level: ties controller and datapath together.
// Key letter: placed while idle. Opening letter of a pair: held as pending; the first
// plaintext letter after a key first sweeps the alphabet into the square, J apart.
// Closing letter or end of message: forms the pair, reads both positions and then both
// cipher cells via one read port per memory and emits when the result register is free.
// Reset clears flags, counts and valids at once; memories stay undefined until written.
`timescale 1ns / 1ps

module playfair_encrypt import pf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  kind_t   kind_i,
  input  letter_t letter_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output letter_t cipher_first_o,
  output letter_t cipher_second_o
);

  pf_cmd_t  cmd;
  pf_stat_t stat;

  pf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .letter_i        (letter_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .cipher_first_o  (cipher_first_o),
    .cipher_second_o (cipher_second_o)
  );

endmodule
